// File: rtl/bsgp_pkg.sv
// Package for the bouncing spot gradient test-pattern generator.
// Holds raster defaults, field widths, reset values, operation and register codes, shared types and a clamp function.
// No dependencies.
`timescale 1ns / 1ps

package bsgp_pkg;

  // Raster defaults and pattern constants.
  localparam int DEF_WIDTH    = 1920;
  localparam int DEF_HEIGHT   = 1080;
  localparam int MID_LEVEL    = 32000;
  localparam int START_MARGIN = 5;

  // Field widths.
  localparam int OP_W        = 2;
  localparam int COORD_W     = 11;
  localparam int RADIUS_W    = 8;
  localparam int DELTA_W     = 15;
  localparam int VEL_W       = 15;
  localparam int SPD_W       = 16;
  localparam int CHAN_W      = 16;
  localparam int SUM_W       = 18;
  localparam int CFG_W       = 15;
  localparam int CFG_IDX_W   = 2;
  localparam int N_ANCHOR    = 6;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  // Register reset values.
  localparam logic [RADIUS_W-1:0]      RADIUS_RST = 8'd25;
  localparam logic [DELTA_W-1:0]       DELTA_RST  = 15'd0;
  localparam logic signed [VEL_W-1:0]  VELX_RST   = 15'sd683;
  localparam logic signed [VEL_W-1:0]  VELY_RST   = -15'sd1153;

  // Operation codes carried in the input transfer.
  typedef enum logic [OP_W-1:0] {
    OP_RESTART = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_PIXEL   = 2'd2,
    OP_IDLE    = 2'd3
  } op_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS = 2'd0,
    CFG_DELTA  = 2'd1,
    CFG_VELX   = 2'd2,
    CFG_VELY   = 2'd3
  } cfg_idx_e;

  // Per-item control that travels alongside the arithmetic pipeline.
  typedef struct packed {
    logic                valid;
    op_e                 op;
    logic [COORD_W-1:0]  cx;
    logic [COORD_W-1:0]  cy;
    logic                in_spot;
    logic [N_ANCHOR-1:0] anear;
    logic [N_ANCHOR-1:0] dz;
  } side_t;

  // Clamp a signed channel sum to the 16-bit code range.
  function automatic logic [CHAN_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [CHAN_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SUM_W'(65535))) begin
      res = '1;
    end else begin
      res = v[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/bsgp_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Imports bsgp_pkg, though the default root width is a local parameter.
`timescale 1ns / 1ps

module bsgp_isqrt import bsgp_pkg::*; #(
  parameter int RW = 20
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [2*RW-1:0] rad_i,
  output logic [RW-1:0]   root_o
);

  logic [RW+1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];

  logic [RW+1:0]   rem_d  [RW];
  logic [RW-1:0]   root_d [RW];
  logic [2*RW-1:0] rad_d  [RW];

  // Each stage brings down two radicand bits and tries one root bit.
  always_comb begin
    logic [RW+1:0]   rin;
    logic [RW-1:0]   oin;
    logic [2*RW-1:0] vin;
    logic [RW+3:0]   ext;
    logic [RW+3:0]   trial;
    for (int s = 0; s < RW; s++) begin
      if (s == 0) begin
        rin = '0;
        oin = '0;
        vin = rad_i;
      end else begin
        rin = rem_q[s-1];
        oin = root_q[s-1];
        vin = rad_q[s-1];
      end
      ext   = {rin, vin[2*(RW-1-s) +: 2]};
      trial = (RW+4)'({oin, 2'b01});
      if (ext >= trial) begin
        rem_d[s]  = (RW+2)'(ext - trial);
        root_d[s] = {oin[RW-2:0], 1'b1};
      end else begin
        rem_d[s]  = (RW+2)'(ext);
        root_d[s] = {oin[RW-2:0], 1'b0};
      end
      rad_d[s] = vin;
    end
  end

  // Stage registers advance together under the pipeline enable.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < RW; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= rad_d[s];
      end
    end
  end

  assign root_o = root_q[RW-1];

endmodule

// File: rtl/bsgp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on bsgp_pkg for the default quotient width; the quotient must fit in QW bits.
`timescale 1ns / 1ps

module bsgp_div import bsgp_pkg::*; #(
  parameter int NW = 36,
  parameter int DW = 21,
  parameter int QW = DELTA_W
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  localparam int TW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  logic [NW-1:0] rem_d [QW];
  logic [DW-1:0] den_d [QW];
  logic [QW-1:0] quo_d [QW];

  // Stage s decides quotient bit QW-1-s against the shifted divisor.
  always_comb begin
    logic [NW-1:0] rin;
    logic [DW-1:0] din;
    logic [QW-1:0] qin;
    logic [TW-1:0] trial;
    for (int s = 0; s < QW; s++) begin
      if (s == 0) begin
        rin = num_i;
        din = den_i;
        qin = '0;
      end else begin
        rin = rem_q[s-1];
        din = den_q[s-1];
        qin = quo_q[s-1];
      end
      trial = TW'(din) << (QW - 1 - s);
      quo_d[s] = qin;
      if (TW'(rin) >= trial) begin
        rem_d[s] = NW'(TW'(rin) - trial);
        quo_d[s][QW-1-s] = 1'b1;
      end else begin
        rem_d[s] = rin;
      end
      den_d[s] = din;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < QW; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// File: rtl/bouncing_spot_gradient_pattern.sv
// Pipeline: three entry stages, RW square-root stages, one ramp set-up stage, 15 divider stages
// and the output register, with RW = max(11, clog2 of raster) + 9.
// Throughput: one item per cycle while the skid slot is empty; an output skid register keeps input
// open while one result waits, and input closes while the slot holds a second result.
// Reset (rst_ni low, asynchronous) restores register defaults and the spot start position.
// Depends on bsgp_pkg, bsgp_isqrt and bsgp_div.
`timescale 1ns / 1ps

module bouncing_spot_gradient_pattern import bsgp_pkg::*; #(
  parameter int WIDTH  = DEF_WIDTH,
  parameter int HEIGHT = DEF_HEIGHT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration write port.
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_data_i,
  // Input stream.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: operation [1:0], column [12:2], row [23:13]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // Output stream.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: red [15:0], green [31:16], blue [47:32], inside_spot [48],
  //        center_x [59:49], center_y [70:60], zero [71]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int MAXD  = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int CW    = $clog2(MAXD);
  localparam int AMW   = (CW > COORD_W) ? CW : COORD_W;
  localparam int MW    = AMW + 8;
  localparam int POS_W = AMW + 10;
  localparam int SQW   = 2 * MW + 1;
  localparam int ASQW  = 2 * AMW + 1;
  localparam int RW    = AMW + 9;
  localparam int DENW  = RW + 1;
  localparam int NW    = RW + 16;
  localparam int QW    = DELTA_W;
  localparam int LAST  = RW + QW;

  localparam logic [POS_W-1:0] YMID = POS_W'((HEIGHT / 2) * 256);
  localparam logic [POS_W-1:0] XRST = POS_W'((START_MARGIN + 25) * 256);
  localparam logic [POS_W-1:0] COL_R = POS_W'(WIDTH - 1);
  localparam logic [POS_W-1:0] COL_M = POS_W'(WIDTH / 2 - 1);
  localparam logic [POS_W-1:0] ROW_B = POS_W'(HEIGHT - 1);

  // Anchor k uses column AX_SEL[k] (0, right, middle) and row AY_SEL[k] (0, bottom).
  localparam int AX_SEL [N_ANCHOR] = '{0, 0, 1, 1, 2, 2};
  localparam int AY_SEL [N_ANCHOR] = '{0, 1, 1, 0, 0, 1};

  // Configuration registers.
  logic [RADIUS_W-1:0]     radius_q;
  logic [DELTA_W-1:0]      delta_q;
  logic signed [VEL_W-1:0] svx_q, svy_q;

  // Spot state.
  logic signed [POS_W-1:0] sx_q, sy_q, sx_d, sy_d;
  logic signed [SPD_W-1:0] vx_q, vy_q, vx_d, vy_d;

  logic en;
  logic acc;

  // Input fields.
  op_e                in_op;
  logic [COORD_W-1:0] in_col, in_row;

  assign in_op  = op_e'(s_axis_tdata[OP_W-1:0]);
  assign in_col = s_axis_tdata[OP_W +: COORD_W];
  assign in_row = s_axis_tdata[OP_W+COORD_W +: COORD_W];

  assign acc           = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = en;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      delta_q  <= DELTA_RST;
      svx_q    <= VELX_RST;
      svy_q    <= VELY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_DELTA:  delta_q  <= cfg_data_i[DELTA_W-1:0];
        CFG_VELX:   svx_q    <= $signed(cfg_data_i[VEL_W-1:0]);
        CFG_VELY:   svy_q    <= $signed(cfg_data_i[VEL_W-1:0]);
        default: ;
      endcase
    end
  end

  // Restart and advance of the spot; each wall test sees the previous one's result.
  always_comb begin
    logic signed [POS_W-1:0] rfix_s, xr, yb;
    logic [POS_W-1:0]        xb, ybb;
    rfix_s = $signed(POS_W'({radius_q, 8'h00}));
    xb     = COL_R - POS_W'(radius_q);
    ybb    = ROW_B - POS_W'(radius_q);
    xr     = $signed({xb[POS_W-9:0], 8'h00});
    yb     = $signed({ybb[POS_W-9:0], 8'h00});
    sx_d   = sx_q;
    sy_d   = sy_q;
    vx_d   = vx_q;
    vy_d   = vy_q;
    unique case (in_op)
      OP_RESTART: begin
        sx_d = $signed(POS_W'({9'(START_MARGIN) + 9'(radius_q), 8'h00}));
        sy_d = $signed(YMID);
        vx_d = SPD_W'(svx_q);
        vy_d = SPD_W'(svy_q);
      end
      OP_ADVANCE: begin
        sx_d = sx_q + POS_W'(vx_q);
        sy_d = sy_q + POS_W'(vy_q);
        if (sx_d >= xr) begin
          vx_d = -vx_d;
          sx_d = xr;
        end
        if (sx_d <= rfix_s) begin
          vx_d = -vx_d;
          sx_d = rfix_s;
        end
        if (sy_d >= yb) begin
          vy_d = -vy_d;
          sy_d = yb;
        end
        if (sy_d <= rfix_s) begin
          vy_d = -vy_d;
          sy_d = rfix_s;
        end
      end
      OP_PIXEL, OP_IDLE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= $signed(XRST);
      sy_q <= $signed(YMID);
      vx_q <= SPD_W'(VELX_RST);
      vy_q <= SPD_W'(VELY_RST);
    end else if (acc) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      vx_q <= vx_d;
      vy_q <= vy_d;
    end
  end

  // Stage 1: distances from the spot centre and from the anchors.
  logic [MW-1:0]  pdx_d, pdy_d, pdx_q, pdy_q;
  logic [AMW-1:0] adx_d [3];
  logic [AMW-1:0] ady_d [2];
  logic [AMW-1:0] adx_q [3];
  logic [AMW-1:0] ady_q [2];
  side_t          side1_d, side1_q, side2_q, side3_d, side3_q;

  always_comb begin
    logic signed [POS_W-1:0] dxs, dys, t;
    logic signed [POS_W-1:0] axv [3];
    logic signed [POS_W-1:0] ayv [2];
    dxs = sx_q - $signed(POS_W'({in_col, 8'h00}));
    dys = sy_q - $signed(POS_W'({in_row, 8'h00}));
    t = (dxs < 0) ? -dxs : dxs;
    pdx_d = t[MW-1:0];
    t = (dys < 0) ? -dys : dys;
    pdy_d = t[MW-1:0];
    axv[0] = '0;
    axv[1] = $signed(COL_R);
    axv[2] = $signed(COL_M);
    ayv[0] = '0;
    ayv[1] = $signed(ROW_B);
    for (int i = 0; i < 3; i++) begin
      t = axv[i] - $signed(POS_W'(in_col));
      t = (t < 0) ? -t : t;
      adx_d[i] = t[AMW-1:0];
    end
    for (int i = 0; i < 2; i++) begin
      t = ayv[i] - $signed(POS_W'(in_row));
      t = (t < 0) ? -t : t;
      ady_d[i] = t[AMW-1:0];
    end
    side1_d        = '0;
    side1_d.valid  = s_axis_tvalid;
    side1_d.op     = in_op;
    side1_d.cx     = sx_d[8 +: COORD_W];
    side1_d.cy     = sy_d[8 +: COORD_W];
  end

  // Stage 2: squares.
  logic [2*MW-1:0]  psx_q, psy_q;
  logic [2*AMW-1:0] asx_q [3];
  logic [2*AMW-1:0] asy_q [2];

  // Stage 3: squared sums, inside test and anchor proximity.
  logic [SQW-1:0]  psq_q;
  logic [ASQW-1:0] asq_q [N_ANCHOR];
  logic [15:0]     rsq;

  assign rsq = 16'(radius_q * radius_q);

  // Stage 3 control word gains the inside flag and the near-anchor flags.
  always_comb begin
    side3_d         = side2_q;
    side3_d.in_spot = (psx_q + SQW'(psy_q)) < SQW'({rsq, 16'h0000});
    for (int k = 0; k < N_ANCHOR; k++) begin
      side3_d.anear[k] = (ASQW'(asx_q[AX_SEL[k]]) + ASQW'(asy_q[AY_SEL[k]]))
                         < ASQW'(rsq);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side1_q <= '0;
      side2_q <= '0;
      side3_q <= '0;
    end else if (en) begin
      side1_q <= side1_d;
      side2_q <= side1_q;
      side3_q <= side3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pdx_q <= pdx_d;
      pdy_q <= pdy_d;
      for (int i = 0; i < 3; i++) begin
        adx_q[i] <= adx_d[i];
        asx_q[i] <= (2*AMW)'(adx_q[i]) * (2*AMW)'(adx_q[i]);
      end
      for (int i = 0; i < 2; i++) begin
        ady_q[i] <= ady_d[i];
        asy_q[i] <= (2*AMW)'(ady_q[i]) * (2*AMW)'(ady_q[i]);
      end
      psx_q <= (2*MW)'(pdx_q) * (2*MW)'(pdx_q);
      psy_q <= (2*MW)'(pdy_q) * (2*MW)'(pdy_q);
      psq_q <= SQW'(psx_q) + SQW'(psy_q);
      for (int k = 0; k < N_ANCHOR; k++) begin
        asq_q[k] <= ASQW'(asx_q[AX_SEL[k]]) + ASQW'(asy_q[AY_SEL[k]]);
      end
    end
  end

  // Square roots: pixel distance and the six anchor distances, 8 fraction bits.
  logic [RW-1:0] pix_dist;
  logic [RW-1:0] d2 [N_ANCHOR];

  bsgp_isqrt #(.RW(RW)) u_sqrt_pix (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ((2*RW)'(psq_q)),
    .root_o (pix_dist)
  );

  for (genvar k = 0; k < N_ANCHOR; k++) begin : g_anchor_sqrt
    bsgp_isqrt #(.RW(RW)) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  ((2*RW)'({asq_q[k], 16'h0000})),
      .root_o (d2[k])
    );
  end

  // Ramp set-up: distance beyond the edge, the shared numerator and the denominators.
  logic [DENW-1:0]     den_d [N_ANCHOR];
  logic [DENW-1:0]     den_q [N_ANCHOR];
  logic [N_ANCHOR-1:0] dz_d;
  logic [NW-1:0]       num_d, num_q;

  always_comb begin
    logic [RW-1:0]   rfix_r, d1;
    logic [DENW-1:0] dsum;
    rfix_r = RW'({radius_q, 8'h00});
    d1     = (pix_dist > rfix_r) ? pix_dist - rfix_r : '0;
    dsum   = DENW'(d1) + DENW'(rfix_r);
    num_d  = NW'(delta_q) * NW'(dsum);
    for (int k = 0; k < N_ANCHOR; k++) begin
      den_d[k] = DENW'(d1) + DENW'(d2[k]);
      dz_d[k]  = (den_d[k] == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= num_d;
      for (int k = 0; k < N_ANCHOR; k++) begin
        den_q[k] <= den_d[k];
      end
    end
  end

  // Dividers: one ramp per anchor.
  logic [QW-1:0] quo [N_ANCHOR];

  for (genvar k = 0; k < N_ANCHOR; k++) begin : g_ramp_div
    bsgp_div #(.NW(NW), .DW(DENW), .QW(QW)) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q),
      .den_i (den_q[k]),
      .quo_o (quo[k])
    );
  end

  // Control line that follows the square-root and divider stages.
  side_t line_q [LAST+1];
  side_t line_dz;

  // The zero-denominator flags join the control word as it enters the dividers.
  always_comb begin
    line_dz    = line_q[RW-1];
    line_dz.dz = dz_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '{default: '0};
    end else if (en) begin
      line_q[0] <= side3_q;
      for (int k = 1; k <= LAST; k++) begin
        if (k == RW) begin
          line_q[k] <= line_dz;
        end else begin
          line_q[k] <= line_q[k-1];
        end
      end
    end
  end

  // Channel sums and saturation.
  side_t                   fin;
  logic [OUT_TDATA_W-1:0]  fin_data;

  always_comb begin
    logic signed [SUM_W-1:0] rmp [N_ANCHOR];
    logic signed [SUM_W-1:0] mid;
    logic [CHAN_W-1:0]       r, g, b, grey;
    fin = line_q[LAST];
    mid = $signed(SUM_W'(MID_LEVEL));
    for (int k = 0; k < N_ANCHOR; k++) begin
      rmp[k] = (fin.anear[k] || fin.dz[k]) ? $signed(SUM_W'(delta_q))
                                            : $signed(SUM_W'(quo[k]));
    end
    grey = sat16(mid - $signed(SUM_W'(delta_q)));
    r = '0;
    g = '0;
    b = '0;
    if (fin.op == OP_PIXEL) begin
      if (fin.in_spot) begin
        r = grey;
        g = grey;
        b = grey;
      end else begin
        r = sat16(mid + rmp[0] - rmp[1]);
        b = sat16(mid - rmp[2] + rmp[3]);
        g = sat16(mid - rmp[4] + rmp[5]);
      end
    end
    fin_data = {1'b0, fin.cy, fin.cx, (fin.op == OP_PIXEL) && fin.in_spot, b, g, r};
  end

  // Output register with a skid slot; the pipeline moves while the slot is empty.
  logic [OUT_TDATA_W-1:0] out_q, sk_q;
  logic                   ov_q, skv_q;
  logic                   pv;

  assign pv = fin.valid;
  assign en = !skv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      skv_q <= 1'b0;
    end else if (skv_q) begin
      if (m_axis_tready) begin
        skv_q <= 1'b0;
      end
    end else if (pv) begin
      ov_q <= 1'b1;
      if (ov_q && !m_axis_tready) begin
        skv_q <= 1'b1;
      end
    end else if (m_axis_tready) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skv_q) begin
      if (m_axis_tready) begin
        out_q <= sk_q;
      end
    end else if (pv) begin
      if (!ov_q || m_axis_tready) begin
        out_q <= fin_data;
      end else begin
        sk_q <= fin_data;
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = out_q;

  // Checks on the skid slot, the entry stage and inside-spot colours.
  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skv_q |-> ov_q)
    else $error("skid slot holds a result while the output register is empty");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skv_q) |-> $past(ov_q && !m_axis_tready))
    else $error("skid slot filled without a stalled output");

  a_entry_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> side1_q.valid)
    else $error("accepted transfer did not reach the first stage");

  a_inside_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[48]) |->
      (m_axis_tdata[15:0] == m_axis_tdata[31:16]) &&
      (m_axis_tdata[31:16] == m_axis_tdata[47:32]))
    else $error("inside-spot pixel with unequal channels");

endmodule

// File: sim/bouncing_spot_gradient_pattern_test.sv
// Self-checking testbench for the bouncing spot gradient test-pattern generator.
// Depends on bsgp_pkg and the bouncing_spot_gradient_pattern RTL.
// Directed rows run first, then random restart, advance and pixel traffic under several settings.
`timescale 1ns / 1ps

module bouncing_spot_gradient_pattern_test;
  import bsgp_pkg::*;

  localparam int RAS_W      = 1920;
  localparam int RAS_H      = 1080;
  localparam int SETTLE_CYC = 60;

  // One output pixel as the block returns it.
  typedef struct {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        in_spot;
    logic [10:0] cx;
    logic [10:0] cy;
  } pixel_t;

  // One row of the directed table; the expected pixel is used only when typed is set.
  typedef struct {
    op_e         op;
    int          col;
    int          row;
    bit          typed;
    pixel_t      want;
  } row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [CFG_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: operation [1:0], column [12:2], row [23:13]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: red [15:0], green [31:16], blue [47:32], inside_spot [48],
  //        center_x [59:49], center_y [70:60], zero [71]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Shadow of the configuration and of the spot state.
  longint spot_radius, ramp_delta, vel_x_start, vel_y_start;
  longint pos_x, pos_y, spd_x, spd_y;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  bit     quiet = 1'b0;
  int     item_no = 0;

  bouncing_spot_gradient_pattern DUT (.*);

  always #10 clk_i = ~clk_i;

  // Floor square root, one result bit at a time.
  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic [15:0] clamp_code(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hffff;
    return v[15:0];
  endfunction

  // Ramp weight toward one anchor; d1 is the distance to the circle edge.
  function automatic longint anchor_ramp(longint col, longint row, longint ax, longint ay,
                                         longint unsigned d1);
    longint unsigned sq, d2, den;
    sq = (ax - col) * (ax - col) + (ay - row) * (ay - row);
    if (sq < spot_radius * spot_radius) return ramp_delta;
    d2 = floor_sqrt(sq << 16);
    den = d1 + d2;
    if (den == 0) return ramp_delta;
    return (ramp_delta * (d1 + spot_radius * 256)) / den;
  endfunction

  function automatic void load_start();
    pos_x = (START_MARGIN + spot_radius) * 256;
    pos_y = (RAS_H / 2) * 256;
    spd_x = vel_x_start;
    spd_y = vel_y_start;
  endfunction

  // Updates the spot state for one item and returns the pixel it produces.
  function automatic pixel_t spot_pixel(op_e op, longint col, longint row);
    pixel_t p;
    longint rfix, xr, yb, dx, dy, pix_dist, hb, wr, cm;
    longint unsigned sq, d1;
    p = '{default: '0};
    rfix = spot_radius * 256;
    case (op)
      OP_RESTART: begin
        load_start();
      end
      OP_ADVANCE: begin
        xr = (RAS_W - 1 - spot_radius) * 256;
        yb = (RAS_H - 1 - spot_radius) * 256;
        pos_x += spd_x;
        pos_y += spd_y;
        if (pos_x >= xr) begin spd_x = -spd_x; pos_x = xr; end
        if (pos_x <= rfix) begin spd_x = -spd_x; pos_x = rfix; end
        if (pos_y >= yb) begin spd_y = -spd_y; pos_y = yb; end
        if (pos_y <= rfix) begin spd_y = -spd_y; pos_y = rfix; end
      end
      OP_PIXEL: begin
        dx = pos_x - col * 256;
        dy = pos_y - row * 256;
        sq = dx * dx + dy * dy;
        if (sq < rfix * rfix) begin
          p.red = clamp_code(MID_LEVEL - ramp_delta);
          p.green = p.red;
          p.blue = p.red;
          p.in_spot = 1'b1;
        end else begin
          pix_dist = floor_sqrt(sq);
          d1 = (pix_dist > rfix) ? pix_dist - rfix : 0;
          wr = RAS_W - 1;
          hb = RAS_H - 1;
          cm = RAS_W / 2 - 1;
          p.red = clamp_code(MID_LEVEL + anchor_ramp(col, row, 0, 0, d1)
                             - anchor_ramp(col, row, 0, hb, d1));
          p.blue = clamp_code(MID_LEVEL - anchor_ramp(col, row, wr, hb, d1)
                              + anchor_ramp(col, row, wr, 0, d1));
          p.green = clamp_code(MID_LEVEL - anchor_ramp(col, row, cm, 0, d1)
                               + anchor_ramp(col, row, cm, hb, d1));
        end
      end
      default: ;
    endcase
    p.cx = pos_x[18:8];
    p.cy = pos_y[18:8];
    return p;
  endfunction

  // Sends one item; the expected pixel is queued at the transfer.
  task automatic send_item(op_e op, int col, int row, bit typed, pixel_t want);
    pixel_t p;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {row[10:0], col[10:0], op};
    do @(posedge clk_i); while (!s_axis_tready);
    p = spot_pixel(op, col, row);
    pending_pixels.push_back(typed ? want : p);
    item_no++;
    if (!quiet && $urandom_range(99) < 41) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_RADIUS: spot_radius = val[7:0];
      CFG_DELTA:  ramp_delta = val;
      CFG_VELX:   vel_x_start = longint'($signed(val));
      default:    vel_y_start = longint'($signed(val));
    endcase
  endtask

  task automatic set_all(int r, int d, int vx, int vy);
    write_reg(CFG_RADIUS, CFG_W'(r));
    write_reg(CFG_DELTA, CFG_W'(d));
    write_reg(CFG_VELX, CFG_W'(vx));
    write_reg(CFG_VELY, CFG_W'(vy));
  endtask

  // Random traffic: mostly advances and pixels, some near the spot, with rare restarts.
  task automatic random_run(int n);
    int k, col, row;
    op_e op;
    pixel_t none;
    none = '{default: '0};
    send_item(OP_RESTART, $urandom_range(2047), $urandom_range(2047), 1'b0, none);
    for (int i = 0; i < n; i++) begin
      quiet = (item_no >= 350 && item_no < 480);
      k = $urandom_range(99);
      op = (k < 3) ? OP_RESTART : (k < 28) ? OP_ADVANCE : (k < 96) ? OP_PIXEL : OP_IDLE;
      k = $urandom_range(99);
      if (k < 40) begin
        col = int'((pos_x >>> 8) + longint'($urandom_range(int'(2 * spot_radius + 4)))
                   - spot_radius - 2);
        row = int'((pos_y >>> 8) + longint'($urandom_range(int'(2 * spot_radius + 4)))
                   - spot_radius - 2);
      end else if (k < 90) begin
        col = $urandom_range(RAS_W - 1);
        row = $urandom_range(RAS_H - 1);
      end else begin
        col = $urandom_range(2047);
        row = $urandom_range(2047);
      end
      send_item(op, col & 32'h7ff, row & 32'h7ff, 1'b0, none);
    end
    quiet = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.red = m_axis_tdata[15:0];
      got.green = m_axis_tdata[31:16];
      got.blue = m_axis_tdata[47:32];
      got.in_spot = m_axis_tdata[48];
      got.cx = m_axis_tdata[59:49];
      got.cy = m_axis_tdata[70:60];
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transfer: %h", m_axis_tdata);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.in_spot !== want.in_spot || got.cx !== want.cx || got.cy !== want.cy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected rgb %0d %0d %0d in %0d c %0d,%0d",
                     want.red, want.green, want.blue, want.in_spot, want.cx, want.cy,
                     " got %0d %0d %0d in %0d c %0d,%0d",
                     got.red, got.green, got.blue, got.in_spot, got.cx, got.cy);
        end
      end
    end
  end

  // Output stall pattern, with a long stretch of steady acceptance.
  always @(posedge clk_i) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 29);
  end

  // Directed table and phases of random traffic.
  initial begin
    row_t rows[$];
    pixel_t mid, zero_px;
    mid = '{16'd32000, 16'd32000, 16'd32000, 1'b0, 11'd30, 11'd540};
    zero_px = '{16'd0, 16'd0, 16'd0, 1'b0, 11'd30, 11'd540};
    rows = '{
      '{OP_PIXEL, 0, 0, 1'b1, mid},
      '{OP_RESTART, 2047, 2047, 1'b1, zero_px},
      '{OP_PIXEL, 30, 540, 1'b1, '{16'd32000, 16'd32000, 16'd32000, 1'b1, 11'd30, 11'd540}},
      '{OP_IDLE, 1365, 682, 1'b1, zero_px},
      '{OP_PIXEL, 2047, 2047, 1'b1, mid},
      '{OP_PIXEL, 1919, 1079, 1'b1, mid},
      '{OP_ADVANCE, 0, 0, 1'b0, zero_px},
      '{OP_PIXEL, 32, 535, 1'b0, zero_px},
      '{OP_ADVANCE, 0, 0, 1'b0, zero_px},
      '{OP_PIXEL, 959, 0, 1'b0, zero_px},
      '{OP_PIXEL, 0, 1079, 1'b0, zero_px},
      '{OP_PIXEL, 1919, 0, 1'b0, zero_px},
      '{OP_PIXEL, 959, 1079, 1'b0, zero_px}
    };
    spot_radius = 25;
    ramp_delta = 0;
    vel_x_start = 683;
    vel_y_start = -1153;
    load_start();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) send_item(rows[i].op, rows[i].col, rows[i].row, rows[i].typed, rows[i].want);
    drain();

    // Extremes of every register, then ordinary settings.
    set_all(1, 32000, 16383, -16384);
    foreach (rows[i]) if (i > 0) send_item(rows[i].op, rows[i].col, rows[i].row, 1'b0, zero_px);
    random_run(120);
    drain();
    set_all(255, 32767, -16384, 16383);
    random_run(120);
    drain();
    set_all(25, 9600, 683, -1153);
    random_run(250);
    drain();
    set_all(200, 32000, 5000, 3000);
    random_run(120);
    drain();
    set_all($urandom_range(255, 1), $urandom_range(32000), $urandom_range(32767),
            $urandom_range(32767));
    random_run(200);
    drain();

    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: files.f
rtl/bsgp_pkg.sv
rtl/bsgp_isqrt.sv
rtl/bsgp_div.sv
rtl/bouncing_spot_gradient_pattern.sv
sim/bouncing_spot_gradient_pattern_test.sv
